FILE: rtl/core/i2c_master_byte_engine_defines.svh
// Assertion macros for the I2C master byte engine checker.
// Used by i2cm_checker; needs clk and rst_n in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// checked outside reset only
`define I2CM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cm assertion failed");

// checked at every edge, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cm assertion failed");

`endif

FILE: rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies.
`default_nettype none
package i2cm_pkg;

  localparam int TICK_W  = 16;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = TICK_W'(32);

  typedef enum logic [2:0] {
    OP_IDLE    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    PH_NONE    = 5'd0,
    PH_ST_SDA0 = 5'd1,
    PH_ST_SCL0 = 5'd2,
    PH_RS_SDA1 = 5'd3,
    PH_RS_SCL1 = 5'd4,
    PH_W_SET   = 5'd5,
    PH_W_HIGH  = 5'd6,
    PH_W_LOW   = 5'd7,
    PH_A_REL   = 5'd8,
    PH_A_HIGH  = 5'd9,
    PH_A_LOW   = 5'd10,
    PH_A_DRIVE = 5'd11,
    PH_R_REL   = 5'd12,
    PH_R_WAIT  = 5'd13,
    PH_R_HIGH  = 5'd14,
    PH_R_LOW   = 5'd15,
    PH_K_SET   = 5'd16,
    PH_K_HIGH  = 5'd17,
    PH_K_LOW   = 5'd18,
    PH_K_SDA0  = 5'd19,
    PH_P_SDA0  = 5'd20,
    PH_P_SCL1  = 5'd21,
    PH_P_SDA1  = 5'd22
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic en;
  } line_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       done;
    logic       busy;
    line_t      line;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/core/i2cm_front.sv
// Input side: accepts items and decodes the command field.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_front import i2cm_pkg::*; (
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // command[2:0] tx_byte[10:3] last_read[11] sda_sample[12]
  input  wire logic        q_full,
  output logic             push,
  output item_t            push_item
);

  op_t op_dec;

  always_comb begin
    unique case (in_tdata[2:0])
      3'd1:    op_dec = OP_START;
      3'd2:    op_dec = OP_RESTART;
      3'd3:    op_dec = OP_STOP;
      3'd4:    op_dec = OP_WRITE;
      3'd5:    op_dec = OP_READ;
      default: op_dec = OP_IDLE;
    endcase
  end

  assign in_tready            = !q_full;
  assign push                 = in_tvalid && !q_full;
  assign push_item.op         = op_dec;
  assign push_item.tx_byte    = in_tdata[10:3];
  assign push_item.last_read  = in_tdata[11];
  assign push_item.sda_sample = in_tdata[12];

endmodule
`default_nettype wire

FILE: rtl/core/i2cm_queue.sv
// Short FIFO of decoded items between the front and the bus engine.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_queue import i2cm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output item_t     head_item
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/i2cm_back.sv
// Bus engine: phase sequencer, tick counter, shifter and result register.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_back import i2cm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [TICK_W-1:0] phase_ticks,
  input  wire logic              head_valid,
  input  item_t                  head_item,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res
);

  op_t               op_r, op_nxt;
  phase_t            ph_r, ph_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              nak_r, nak_nxt;
  line_t             line_r, line_nxt;
  logic              ack_r, ack_nxt;
  logic              res_valid_r;
  res_t              res_r, res_nxt;

  logic [TICK_W-1:0] phase_len;
  logic [TICK_W-1:0] tick_inc;
  logic [3:0]        bit_inc;
  phase_t            nx;
  logic              done;

  function automatic line_t enter_line(phase_t ph, line_t ln, logic msb, logic nak);
    line_t o;
    o = ln;
    unique case (ph)
      PH_ST_SDA0, PH_K_SDA0: o.sda = 1'b0;
      PH_ST_SCL0, PH_W_LOW, PH_A_LOW, PH_R_WAIT, PH_R_LOW, PH_K_LOW: o.scl = 1'b0;
      PH_RS_SDA1, PH_P_SDA1: begin
        o.sda = 1'b1;
        o.en  = 1'b1;
      end
      PH_RS_SCL1, PH_W_HIGH, PH_A_HIGH, PH_R_HIGH, PH_K_HIGH, PH_P_SCL1: o.scl = 1'b1;
      PH_W_SET: begin
        o.sda = msb;
        o.en  = 1'b1;
      end
      PH_A_REL, PH_R_REL: begin
        o.en  = 1'b0;
        o.sda = 1'b1;
      end
      PH_A_DRIVE, PH_P_SDA0: begin
        o.en  = 1'b1;
        o.sda = 1'b0;
      end
      PH_K_SET: begin
        o.en  = 1'b1;
        o.sda = nak;
      end
      default: o = ln;
    endcase
    return o;
  endfunction

  assign pop       = head_valid && (!res_valid_r || res_ready);
  assign phase_len = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
  assign tick_inc  = tick_r + TICK_W'(1);
  assign bit_inc   = bit_cnt_r + 4'd1;

  always_comb begin
    op_nxt      = op_r;
    ph_nxt      = ph_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    nak_nxt     = nak_r;
    line_nxt    = line_r;
    ack_nxt     = ack_r;
    nx          = PH_NONE;
    done        = 1'b0;
    res_nxt     = '0;

    if (op_r != OP_IDLE) begin
      tick_nxt = tick_inc;
      if (tick_inc >= phase_len) begin
        unique case (ph_r)
          PH_ST_SDA0: nx = PH_ST_SCL0;
          PH_ST_SCL0: begin
            bit_cnt_nxt = 4'd0;
            nx          = PH_W_SET;
          end
          PH_RS_SDA1: nx = PH_RS_SCL1;
          PH_RS_SCL1: nx = PH_ST_SDA0;
          PH_W_SET:   nx = PH_W_HIGH;
          PH_W_HIGH:  nx = PH_W_LOW;
          PH_W_LOW: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            nx          = bit_inc[3] ? PH_A_REL : PH_W_SET;
          end
          PH_A_REL: nx = PH_A_HIGH;
          PH_A_HIGH: begin
            ack_nxt = !head_item.sda_sample;
            nx      = PH_A_LOW;
          end
          PH_A_LOW: nx = PH_A_DRIVE;
          PH_R_REL: begin
            bit_cnt_nxt = 4'd0;
            nx          = PH_R_WAIT;
          end
          PH_R_WAIT: nx = PH_R_HIGH;
          PH_R_HIGH: begin
            shift_nxt   = {shift_r[6:0], head_item.sda_sample};
            bit_cnt_nxt = bit_inc;
            nx          = bit_inc[3] ? PH_R_LOW : PH_R_WAIT;
          end
          PH_R_LOW:  nx = PH_K_SET;
          PH_K_SET:  nx = PH_K_HIGH;
          PH_K_HIGH: nx = PH_K_LOW;
          PH_K_LOW:  nx = PH_K_SDA0;
          PH_P_SDA0: nx = PH_P_SCL1;
          PH_P_SCL1: nx = PH_P_SDA1;
          default:   nx = PH_NONE;
        endcase
        if (nx == PH_NONE) begin
          done = 1'b1;
          if (op_r == OP_READ) begin
            res_nxt.rx_byte = shift_nxt;
          end else if (op_r != OP_STOP) begin
            res_nxt.ack_ok = ack_nxt;
          end
          op_nxt   = OP_IDLE;
          ph_nxt   = PH_NONE;
          tick_nxt = '0;
        end else begin
          ph_nxt   = nx;
          tick_nxt = '0;
          line_nxt = enter_line(nx, line_r, shift_nxt[7], nak_r);
        end
      end
    end else if (head_item.op != OP_IDLE) begin
      op_nxt      = head_item.op;
      bit_cnt_nxt = 4'd0;
      ack_nxt     = 1'b0;
      tick_nxt    = '0;
      unique case (head_item.op)
        OP_READ: begin
          shift_nxt = 8'd0;
          nak_nxt   = head_item.last_read;
          ph_nxt    = PH_R_REL;
        end
        OP_STOP: ph_nxt = PH_P_SDA0;
        OP_RESTART: begin
          shift_nxt = head_item.tx_byte;
          ph_nxt    = PH_RS_SDA1;
        end
        OP_WRITE: begin
          shift_nxt = head_item.tx_byte;
          ph_nxt    = PH_W_SET;
        end
        default: begin
          shift_nxt = head_item.tx_byte;
          ph_nxt    = PH_ST_SDA0;
        end
      endcase
      line_nxt = enter_line(ph_nxt, line_r, shift_nxt[7], nak_nxt);
    end

    res_nxt.done = done;
    res_nxt.busy = (op_nxt != OP_IDLE);
    res_nxt.line = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      ph_r        <= PH_NONE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      nak_r       <= 1'b0;
      line_r      <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
      ack_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        op_r      <= op_nxt;
        ph_r      <= ph_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        tick_r    <= tick_nxt;
        nak_r     <= nak_nxt;
        line_r    <= line_nxt;
        ack_r     <= ack_nxt;
      end
      if (pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

FILE: rtl/core/i2c_master_byte_engine.sv
// Top level of the byte-level I2C bus master: front decoder, item queue, bus engine.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_back.
//
// Usage: each in_ item is one timebase tick carrying the sampled SDA level and,
// while the master is idle, an optional command (start, restart, stop, write,
// read). Every accepted item yields exactly one out_ item with the SCL/SDA
// levels, the SDA enable, busy, a done pulse, ack_ok and rx_byte.
// phase_ticks is written through cfg_we/cfg_wdata (reset value 32, 0 acts
// as 1); write it only while the block is idle.
// An item's result passes the queue and then the result register on its way to out_.
// Throughput: one item per cycle while out_ is not stalled; a two-entry queue
// separates the input decoder from the engine.
// When the out_ receiver stalls, the result register holds and the queue
// fills; in_tready drops once both entries are taken.
// Reset (rst_n low, synchronous) idles the engine with SCL high and SDA
// driven high, empties the queue and clears out_tvalid.
`default_nettype none
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata,  // phase_ticks
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // command[2:0] tx_byte[10:3] last_read[11]
                                             // sda_sample[12] zero[15:13]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata   // scl[0] sda[1] sda_en[2] busy[3] done[4]
                                             // ack_ok[5] rx_byte[13:6] zero[15:14]
);

  logic [TICK_W-1:0] phase_ticks_r;
  logic              push, q_full, pop, head_valid;
  item_t             push_item, head_item;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {2'b00, res.rx_byte, res.ack_ok, res.done, res.busy,
                      res.line.en, res.line.sda, res.line.scl};

endmodule
`default_nettype wire

FILE: rtl/core/i2cm_checker.sv
// Port-level checker for i2c_master_byte_engine, attached by bind.
// Depends on i2c_master_byte_engine_defines.svh.
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"
module i2cm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  `I2CM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `I2CM_ASSERT(a_done_not_busy, out_tvalid && out_tdata[4] |-> !out_tdata[3])
  `I2CM_ASSERT(a_rx_only_done, out_tvalid && !out_tdata[4] |-> out_tdata[13:6] == 8'd0)
  `I2CM_ASSERT(a_ack_only_done, out_tvalid && out_tdata[5] |-> out_tdata[4])
  `I2CM_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid)

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
